>>> rtl/core/wrp_pkg.sv
// Package for the RIFF/WAVE PCM stream parser: phase codes, status codes,
// chunk tags, the parser state type and the burst type shared by the parser
// and emitter. No dependencies.
`default_nettype none
package wrp_pkg;

	localparam int MaxChannels = 8;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_HEADER   = 3'd1;
	localparam logic [2:0] PH_CHUNKHDR = 3'd2;
	localparam logic [2:0] PH_FMT      = 3'd3;
	localparam logic [2:0] PH_SKIP     = 3'd4;
	localparam logic [2:0] PH_DATA     = 3'd5;
	localparam logic [2:0] PH_DONE     = 3'd6;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
	localparam logic [2:0] ST_NO_FRAMES = 3'd2;
	localparam logic [2:0] ST_TOO_MANY  = 3'd3;
	localparam logic [2:0] ST_SHORT_FMT = 3'd4;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
	localparam logic [15:0] FMT_FLOAT      = 16'd3;

	typedef struct packed {
		logic [2:0]  phase;
		logic [4:0]  fbi;
		logic [31:0] tag;
		logic [31:0] ctag;
		logic [32:0] left;
		logic        pad;
		logic [15:0] ftag;
		logic [15:0] sub;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [15:0] bits;
		logic        fvalid;
		logic [31:0] asm;
		logic [1:0]  sbyte;
		logic [2:0]  chidx;
		logic [31:0] frames;
		logic [2:0]  err;
	} parse_state_t;

	typedef struct packed {
		logic [3:0]       n_samp;
		logic             has_end;
		logic [2:0]       status;
		logic [31:0]      frames;
		logic [31:0]      rate;
		logic [15:0]      chans;
		logic [15:0]      bits;
		logic             is_float;
		logic [7:0][31:0] samples;
	} burst_t;

endpackage
`default_nettype wire

>>> rtl/core/wrp_parser.sv
// Byte parser: walks the RIFF header, chunks and fmt fields, assembles
// samples into the frame buffer and describes each request's results.
// Depends on wrp_pkg.
`default_nettype none
module wrp_parser import wrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  file_byte,
	input  wire logic        first_byte,
	input  wire logic        final_byte,
	output burst_t           burst
);

	parse_state_t st_q;
	parse_state_t nx;
	logic [7:0][31:0] fb_q;
	logic        wr_en;
	logic [2:0]  wr_idx;
	logic [31:0] wr_val;

	always_comb begin
		logic [4:0]  k;
		logic [32:0] padded;
		logic [2:0]  nb;
		logic [31:0] an;
		logic [31:0] v;
		logic [15:0] ft;
		nx = st_q;
		burst = '0;
		wr_en = 1'b0;
		wr_idx = st_q.chidx;
		wr_val = '0;
		k = '0;
		padded = '0;
		nb = '0;
		an = '0;
		v = '0;
		ft = '0;
		if (first_byte) begin
			nx = '0;
			nx.phase = PH_HEADER;
		end
		case (nx.phase)
			PH_HEADER: begin
				nx.tag = {file_byte, nx.tag[31:8]};
				if (nx.fbi == 5'd3 && nx.tag != TAG_RIFF) begin
					nx.err = ST_NOT_WAVE;
					nx.phase = PH_DONE;
				end else if (nx.fbi == 5'd11) begin
					if (nx.tag != TAG_WAVE) begin
						nx.err = ST_NOT_WAVE;
						nx.phase = PH_DONE;
					end else begin
						nx.fbi = '0;
						nx.phase = PH_CHUNKHDR;
					end
				end else begin
					nx.fbi = nx.fbi + 5'd1;
				end
			end
			PH_CHUNKHDR: begin
				nx.tag = {file_byte, nx.tag[31:8]};
				if (nx.fbi == 5'd3) begin
					nx.ctag = nx.tag;
				end
				if (nx.fbi >= 5'd7) begin
					padded = {1'b0, nx.tag} + {32'd0, nx.tag[0]};
					nx.fbi = '0;
					if (nx.ctag == TAG_FMT) begin
						if (nx.tag < 32'd16) begin
							nx.err = ST_SHORT_FMT;
							nx.phase = PH_DONE;
						end else begin
							nx.left = padded;
							nx.pad = nx.tag[0];
							nx.sub = '0;
							nx.phase = PH_FMT;
						end
					end else if (nx.ctag == TAG_DATA && nx.fvalid) begin
						if (nx.tag == '0) begin
							nx.phase = PH_DONE;
						end else begin
							nx.left = {1'b0, nx.tag};
							nx.asm = '0;
							nx.sbyte = '0;
							nx.chidx = '0;
							nx.phase = PH_DATA;
						end
					end else begin
						nx.left = padded;
						nx.phase = (padded == '0) ? PH_CHUNKHDR : PH_SKIP;
					end
				end else begin
					nx.fbi = nx.fbi + 5'd1;
				end
			end
			PH_FMT: begin
				if (!(nx.pad && nx.left == 33'd1)) begin
					k = nx.fbi;
					if (k < 5'd2) begin
						if (k[0]) nx.ftag[15:8] = file_byte;
						else nx.ftag[7:0] = file_byte;
					end else if (k < 5'd4) begin
						if (k[0]) nx.chans[15:8] = file_byte;
						else nx.chans[7:0] = file_byte;
					end else if (k < 5'd8) begin
						case (k[1:0])
							2'd0: nx.rate[7:0] = file_byte;
							2'd1: nx.rate[15:8] = file_byte;
							2'd2: nx.rate[23:16] = file_byte;
							default: nx.rate[31:24] = file_byte;
						endcase
					end else if (k == 5'd14 || k == 5'd15) begin
						if (k[0]) nx.bits[15:8] = file_byte;
						else nx.bits[7:0] = file_byte;
					end else if (k == 5'd24 || k == 5'd25) begin
						if (k[0]) nx.sub[15:8] = file_byte;
						else nx.sub[7:0] = file_byte;
					end
					if (nx.fbi < 5'd31) nx.fbi = nx.fbi + 5'd1;
				end
				nx.left = nx.left - 33'd1;
				if (nx.left == '0) begin
					ft = nx.ftag;
					if (ft == FMT_EXTENSIBLE && nx.fbi >= 5'd26) nx.ftag = nx.sub;
					if (nx.chans > 16'(MaxChannels)) begin
						nx.err = ST_TOO_MANY;
						nx.phase = PH_DONE;
					end else begin
						nx.fvalid = (nx.chans != '0) && (nx.rate != '0) &&
							(nx.bits == 16'd8 || nx.bits == 16'd16 ||
							 nx.bits == 16'd24 || nx.bits == 16'd32);
						nx.fbi = '0;
						nx.phase = PH_CHUNKHDR;
					end
				end
			end
			PH_SKIP: begin
				nx.left = nx.left - 33'd1;
				if (nx.left == '0) begin
					nx.fbi = '0;
					nx.phase = PH_CHUNKHDR;
				end
			end
			PH_DATA: begin
				nb = nx.bits[5:3];
				an = nx.asm | ({24'd0, file_byte} << {nx.sbyte, 3'b000});
				case (nb)
					3'd2: v = {an[15:0], 16'd0};
					3'd3: v = {an[23:0], 8'd0};
					3'd4: v = an;
					default: v = {an[7:0] ^ 8'h80, 24'd0};
				endcase
				if ({1'b0, nx.sbyte} + 3'd1 >= nb) begin
					wr_en = 1'b1;
					wr_idx = nx.chidx;
					wr_val = v;
					nx.asm = '0;
					nx.sbyte = '0;
					if ({13'd0, nx.chidx} + 16'd1 >= nx.chans) begin
						nx.frames = nx.frames + 32'd1;
						burst.n_samp = nx.chans[3:0];
						nx.chidx = '0;
					end else begin
						nx.chidx = nx.chidx + 3'd1;
					end
				end else begin
					nx.asm = an;
					nx.sbyte = nx.sbyte + 2'd1;
				end
				nx.left = nx.left - 33'd1;
				if (nx.left == '0) nx.phase = PH_DONE;
			end
			default: begin
			end
		endcase
		if (final_byte && nx.phase != PH_IDLE) begin
			burst.has_end = 1'b1;
			if (nx.phase == PH_HEADER) burst.status = ST_NOT_WAVE;
			else if (nx.err != ST_OK) burst.status = nx.err;
			else burst.status = (nx.frames == '0) ? ST_NO_FRAMES : ST_OK;
			nx.phase = PH_IDLE;
		end
		burst.frames = nx.frames;
		burst.rate = nx.rate;
		burst.chans = nx.chans;
		burst.bits = nx.bits;
		burst.is_float = (nx.ftag == FMT_FLOAT) && (nx.bits == 16'd32);
		burst.samples = fb_q;
		if (wr_en) burst.samples[wr_idx] = wr_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take) begin
			st_q <= nx;
		end
	end

	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			fb_q[wr_idx] <= wr_val;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/wrp_emitter.sv
// Result register and serialiser: holds one request's burst and hands out
// its channel samples and end record one per cycle while out_stall is low. Depends on wrp_pkg.
`default_nettype none
module wrp_emitter import wrp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire burst_t       burst,
	output logic              busy,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic              kind,
	output logic signed [31:0] sample_value,
	output logic [2:0]        channel,
	output logic              run_last,
	output logic              is_float,
	output logic [31:0]       sample_rate,
	output logic [15:0]       channel_count,
	output logic [15:0]       sample_bits,
	output logic [31:0]       frame_count,
	output logic [2:0]        status
);

	burst_t      desc_q;
	logic        valid_q;
	logic [3:0]  idx_q;
	logic [3:0]  total;
	logic        is_sample;
	logic        pop;
	logic        done;

	assign total = desc_q.n_samp + {3'd0, desc_q.has_end};
	assign is_sample = idx_q < desc_q.n_samp;
	assign run_last = (idx_q == total - 4'd1);
	assign pop = valid_q && !out_stall;
	assign done = pop && run_last;
	assign busy = valid_q && !done;
	assign out_valid = valid_q;

	assign kind = !is_sample;
	assign sample_value = is_sample ? desc_q.samples[idx_q[2:0]] : '0;
	assign channel = is_sample ? idx_q[2:0] : '0;
	assign status = is_sample ? ST_OK : desc_q.status;
	assign is_float = desc_q.is_float;
	assign sample_rate = desc_q.rate;
	assign channel_count = desc_q.chans;
	assign sample_bits = desc_q.bits;
	assign frame_count = desc_q.frames;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= burst;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < total)
		else $error("result index beyond burst length");
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !run_last) |=> valid_q)
		else $error("burst dropped before its last result");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy)
		else $error("burst loaded over one still draining");

endmodule
`default_nettype wire

>>> rtl/core/wav_riff_pcm_stream_parser.sv
// Top level of the RIFF/WAVE PCM stream parser.
// Depends on wrp_pkg, wrp_parser and wrp_emitter.
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | file_byte, first_byte, final_byte
//   out     | out_valid / out_stall| kind, sample_value, channel, run_last, is_float,
//           |                      | sample_rate, channel_count, sample_bits,
//           |                      | frame_count, status
//
// A byte is taken every cycle while no results are waiting; a byte that
// completes a frame or ends the file gives up to nine results, one per cycle while out_stall is low.
// The next byte is taken in the cycle that the last of those results leaves.
// Reset returns the parser to idle, awaiting a first byte.
`default_nettype none
module wav_riff_pcm_stream_parser import wrp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   file_byte,
	input  wire logic         first_byte,
	input  wire logic         final_byte,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic              kind,
	output logic signed [31:0] sample_value,
	output logic [2:0]        channel,
	output logic              run_last,
	output logic              is_float,
	output logic [31:0]       sample_rate,
	output logic [15:0]       channel_count,
	output logic [15:0]       sample_bits,
	output logic [31:0]       frame_count,
	output logic [2:0]        status
);

	burst_t burst;
	logic   take;
	logic   busy;

	assign in_stall = busy;
	assign take = in_valid && !busy;

	wrp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.file_byte  (file_byte),
		.first_byte (first_byte),
		.final_byte (final_byte),
		.burst      (burst)
	);

	wrp_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (take && (burst.n_samp != '0 || burst.has_end)),
		.burst         (burst),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.sample_value  (sample_value),
		.channel       (channel),
		.run_last      (run_last),
		.is_float      (is_float),
		.sample_rate   (sample_rate),
		.channel_count (channel_count),
		.sample_bits   (sample_bits),
		.frame_count   (frame_count),
		.status        (status)
	);

endmodule
`default_nettype wire

>>> verif/tb_wav_riff_pcm_stream_parser.sv
// Testbench for wav_riff_pcm_stream_parser: feeds whole WAV files byte by byte,
// predicts each sample and end record in a parser model of its own and checks the
// results in order. Depends on wrp_pkg and the parser RTL.
`default_nettype none
module tb_wav_riff_pcm_stream_parser;
	import wrp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 3000;
	localparam logic [31:0] TAG_LIST = 32'h5453_494C;
	localparam logic [15:0] FMT_PCM = 16'd1;

	typedef struct {
		logic        kind;
		logic [31:0] val;
		logic [2:0]  ch;
		logic        last;
		logic        flt;
		logic [31:0] rate;
		logic [15:0] chans;
		logic [15:0] bits;
		logic [31:0] frames;
		logic [2:0]  st;
	} wav_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] file_byte = 8'd0;
	logic first_byte = 1'b0;
	logic final_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic signed [31:0] sample_value;
	logic [2:0] channel;
	logic run_last;
	logic is_float;
	logic [31:0] sample_rate;
	logic [15:0] channel_count;
	logic [15:0] sample_bits;
	logic [31:0] frame_count;
	logic [2:0] status;

	wav_riff_pcm_stream_parser dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	wav_result_t pending_results[$];
	byte unsigned wav_bytes[$];
	int error_count = 0;
	int bytes_sent = 0;
	int hold_req = 0;
	int hold_left = 0;
	bit quiet = 1'b0;
	int stuck_cycles = 0;

	// Parser model state.
	logic [2:0]  m_phase = PH_IDLE;
	int          m_fbi;
	logic [31:0] m_tag, m_ctag;
	logic [32:0] m_left;
	logic        m_pad;
	logic [15:0] m_ftag, m_sub, m_chans, m_bits;
	logic [31:0] m_rate;
	logic        m_fvalid;
	logic [31:0] m_asm;
	int          m_sbyte, m_chidx;
	logic [31:0] m_fbuf[8];
	logic [31:0] m_frames;
	logic [2:0]  m_err;
	wav_result_t m_burst[$];

	function automatic void clear_file();
		m_fbi = 0; m_tag = '0; m_ctag = '0; m_left = '0; m_pad = 1'b0;
		m_ftag = '0; m_sub = '0; m_chans = '0; m_rate = '0; m_bits = '0;
		m_fvalid = 1'b0; m_asm = '0; m_sbyte = 0; m_chidx = 0;
		m_frames = '0; m_err = ST_OK;
		for (int i = 0; i < 8; i++) m_fbuf[i] = '0;
	endfunction

	function automatic void stop_file(logic [2:0] code);
		m_err = code;
		m_phase = PH_DONE;
	endfunction

	function automatic void add_result(logic k, logic [31:0] v, logic [2:0] c, logic [2:0] s);
		wav_result_t r;
		r.kind = k; r.val = v; r.ch = c; r.last = 1'b0;
		r.flt = (m_ftag == FMT_FLOAT && m_bits == 16'd32);
		r.rate = m_rate; r.chans = m_chans; r.bits = m_bits; r.frames = m_frames; r.st = s;
		m_burst.push_back(r);
	endfunction

	function automatic void open_chunk(logic [31:0] size);
		logic [32:0] padded;
		padded = {1'b0, size} + size[0];
		m_fbi = 0;
		if (m_ctag == TAG_FMT) begin
			if (size < 16) begin
				stop_file(ST_SHORT_FMT);
			end else begin
				m_left = padded; m_pad = size[0]; m_sub = '0; m_phase = PH_FMT;
			end
		end else if (m_ctag == TAG_DATA && m_fvalid) begin
			if (size == 0) begin
				m_phase = PH_DONE;
			end else begin
				m_left = {1'b0, size}; m_asm = '0; m_sbyte = 0; m_chidx = 0;
				m_phase = PH_DATA;
			end
		end else begin
			m_left = padded;
			m_phase = (padded == 0) ? PH_CHUNKHDR : PH_SKIP;
		end
	endfunction

	function automatic void fmt_step(logic [7:0] b);
		int k;
		k = m_fbi;
		if (!(m_pad && m_left == 1)) begin
			if (k < 2) m_ftag[8*(k%2) +: 8] = b;
			else if (k < 4) m_chans[8*(k%2) +: 8] = b;
			else if (k < 8) m_rate[8*(k%4) +: 8] = b;
			else if (k == 14 || k == 15) m_bits[8*(k%2) +: 8] = b;
			else if (k == 24 || k == 25) m_sub[8*(k%2) +: 8] = b;
			if (m_fbi < 31) m_fbi++;
		end
		m_left--;
		if (m_left != 0) return;
		if (m_ftag == FMT_EXTENSIBLE && m_fbi >= 26) m_ftag = m_sub;
		if (m_chans > MaxChannels) begin
			stop_file(ST_TOO_MANY);
			return;
		end
		m_fvalid = m_chans > 0 && m_rate > 0 &&
			(m_bits == 8 || m_bits == 16 || m_bits == 24 || m_bits == 32);
		m_fbi = 0;
		m_phase = PH_CHUNKHDR;
	endfunction

	function automatic void sample_step(logic [7:0] b);
		int nbytes;
		logic [31:0] v;
		nbytes = m_bits / 8;
		if (m_sbyte < 4) m_asm |= 32'(b) << (8 * m_sbyte);
		m_sbyte++;
		if (m_sbyte >= nbytes) begin
			if (nbytes <= 1) v = (m_asm ^ 32'h80) << 24;
			else v = m_asm << (32 - 8 * nbytes);
			m_fbuf[m_chidx % 8] = v;
			m_asm = '0;
			m_sbyte = 0;
			if (m_chidx + 1 >= m_chans) begin
				m_frames++;
				for (int c = 0; c < m_chans && c < 8; c++) add_result(1'b0, m_fbuf[c], 3'(c), ST_OK);
				m_chidx = 0;
			end else begin
				m_chidx = (m_chidx + 1) % 8;
			end
		end
		m_left--;
		if (m_left == 0) m_phase = PH_DONE;
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic f, logic l);
		logic [2:0] st;
		m_burst.delete();
		if (f) begin
			clear_file();
			m_phase = PH_HEADER;
		end
		if (m_phase == PH_IDLE) return;
		case (m_phase)
			PH_HEADER: begin
				m_tag = {b, m_tag[31:8]};
				if (m_fbi == 3 && m_tag != TAG_RIFF) begin
					stop_file(ST_NOT_WAVE);
				end else if (m_fbi == 11) begin
					if (m_tag != TAG_WAVE) begin
						stop_file(ST_NOT_WAVE);
					end else begin
						m_fbi = 0;
						m_phase = PH_CHUNKHDR;
					end
				end else begin
					m_fbi++;
				end
			end
			PH_CHUNKHDR: begin
				m_tag = {b, m_tag[31:8]};
				if (m_fbi == 3) m_ctag = m_tag;
				if (m_fbi >= 7) open_chunk(m_tag);
				else m_fbi++;
			end
			PH_FMT: fmt_step(b);
			PH_SKIP: begin
				m_left--;
				if (m_left == 0) begin
					m_fbi = 0;
					m_phase = PH_CHUNKHDR;
				end
			end
			PH_DATA: sample_step(b);
			default: ;
		endcase
		if (l) begin
			if (m_phase == PH_HEADER) st = ST_NOT_WAVE;
			else if (m_err != ST_OK) st = m_err;
			else st = (m_frames == 0) ? ST_NO_FRAMES : ST_OK;
			add_result(1'b1, '0, '0, st);
			m_phase = PH_IDLE;
		end
		if (m_burst.size() > 0) m_burst[m_burst.size() - 1].last = 1'b1;
		foreach (m_burst[i]) pending_results.push_back(m_burst[i]);
	endfunction

	task automatic send_byte(logic [7:0] b, logic f, logic l);
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		file_byte <= b;
		first_byte <= f;
		final_byte <= l;
		do @(posedge clk); while (in_stall);
		predict_byte(b, f, l);
		bytes_sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_file(bit with_final);
		foreach (wav_bytes[i])
			send_byte(wav_bytes[i], i == 0, with_final && i == wav_bytes.size() - 1);
	endtask

	function automatic void put16(logic [15:0] v);
		wav_bytes.push_back(v[7:0]);
		wav_bytes.push_back(v[15:8]);
	endfunction

	function automatic void put32(logic [31:0] v);
		put16(v[15:0]);
		put16(v[31:16]);
	endfunction

	// Builds a file: optional LIST chunk, fmt chunk, data chunk whose declared size
	// may differ from the bytes actually supplied, then trailing bytes.
	function automatic void make_wav(logic [15:0] ftag, logic [15:0] chans, logic [31:0] rate,
			logic [15:0] bits, logic [15:0] sub, int fmt_len, int junk_len,
			int data_size, int data_bytes, int tail);
		wav_bytes.delete();
		put32(TAG_RIFF); put32($urandom); put32(TAG_WAVE);
		if (junk_len >= 0) begin
			put32(TAG_LIST); put32(junk_len);
			repeat (junk_len + junk_len % 2) wav_bytes.push_back($urandom);
		end
		put32(TAG_FMT); put32(fmt_len);
		for (int i = 0; i < fmt_len + fmt_len % 2; i++) begin
			case (i)
				0, 1: wav_bytes.push_back(ftag[8*(i%2) +: 8]);
				2, 3: wav_bytes.push_back(chans[8*(i%2) +: 8]);
				4, 5, 6, 7: wav_bytes.push_back(rate[8*(i%4) +: 8]);
				14, 15: wav_bytes.push_back(bits[8*(i%2) +: 8]);
				24, 25: wav_bytes.push_back(sub[8*(i%2) +: 8]);
				default: wav_bytes.push_back($urandom);
			endcase
		end
		put32(TAG_DATA); put32(data_size);
		repeat (data_bytes + tail) wav_bytes.push_back($urandom);
	endfunction

	function automatic void make_random_wav();
		logic [15:0] ftag, chans, bits, sub;
		logic [31:0] rate;
		int fmt_len, fb, dsize, dbytes;
		case ($urandom_range(9))
			0: bits = $urandom;
			1, 2: bits = 16'd8;
			3, 4: bits = 16'd16;
			5, 6: bits = 16'd24;
			default: bits = 16'd32;
		endcase
		chans = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 10)) : 16'($urandom_range(1, 8));
		rate = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
		case ($urandom_range(5))
			0: ftag = FMT_FLOAT;
			1: ftag = FMT_EXTENSIBLE;
			2: ftag = $urandom;
			default: ftag = FMT_PCM;
		endcase
		sub = $urandom_range(1) ? FMT_FLOAT : FMT_PCM;
		case ($urandom_range(9))
			0: fmt_len = $urandom_range(0, 15);
			1: fmt_len = 17;
			2, 3: fmt_len = 40;
			4: fmt_len = 18;
			default: fmt_len = 16;
		endcase
		fb = (chans == 0 ? 1 : chans) * ((bits / 8) == 0 ? 1 : bits / 8);
		if (fb > 16) fb = 16;
		dsize = $urandom_range(0, 3) * fb + ($urandom_range(3) == 0 ? $urandom_range(0, 3) : 0);
		dbytes = ($urandom_range(5) == 0) ? $urandom_range(0, dsize) : dsize;
		make_wav(ftag, chans, rate, bits, sub, fmt_len,
			$urandom_range(2) == 0 ? int'($urandom_range(0, 5)) : -1,
			dsize, dbytes, $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
	endfunction

	task automatic test_bytes_before_first();
		send_byte(8'h52, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_pcm_formats();
		make_wav(FMT_PCM, 1, 8000, 8, 0, 16, -1, 4, 4, 0); send_file(1);
		make_wav(FMT_EXTENSIBLE, 2, 1, 32, FMT_FLOAT, 26, -1, 8, 8, 0); send_file(1);
	endtask

	task automatic test_broken_files();
		make_wav(FMT_PCM, 1, 8000, 8, 0, 16, -1, 2, 2, 0);
		wav_bytes[1] = 8'h00;
		wav_bytes = wav_bytes[0:7];
		send_file(1);
		make_wav(FMT_PCM, 1, 8000, 8, 0, 16, -1, 2, 2, 0);
		wav_bytes[10] = 8'h00;
		wav_bytes = wav_bytes[0:15];
		send_file(1);
		make_wav(FMT_PCM, 1, 8000, 8, 0, 16, -1, 2, 2, 0);
		wav_bytes = wav_bytes[0:5];
		send_file(1);
		make_wav(FMT_PCM, 1, 8000, 8, 0, 14, -1, 2, 2, 0); send_file(1);
		make_wav(FMT_PCM, 9, 8000, 8, 0, 16, -1, 9, 0, 0); send_file(1);
		make_wav(FMT_PCM, 2, 8000, 16, 0, 17, 3, 9, 9, 0); send_file(1);
	endtask

	task automatic test_backpressure();
		go_idle();
		wait (pending_results.size() == 0);
		hold_req = 300;
		make_wav(FMT_PCM, 8, 48000, 16, 0, 16, -1, 32, 32, 0);
		send_file(1);
		go_idle();
		wait (pending_results.size() == 0);
	endtask

	task automatic test_random_files();
		int start_bytes;
		start_bytes = bytes_sent;
		quiet = 1'b1;
		while (bytes_sent < 430) begin
			if (bytes_sent - start_bytes > 40) quiet = 1'b0;
			if ($urandom_range(9) < 8) begin
				make_random_wav();
				send_file($urandom_range(9) != 0);
			end else begin
				repeat ($urandom_range(1, 12))
					send_byte($urandom, $urandom_range(7) == 0, $urandom_range(7) == 0);
			end
		end
		quiet = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && $urandom_range(99) < 13;
		end
	end

	always @(posedge clk) begin
		wav_result_t exp_r;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10) $display("unexpected result kind=%0d value=%h", kind, sample_value);
			end else begin
				exp_r = pending_results.pop_front();
				if (kind !== exp_r.kind || sample_value !== exp_r.val || channel !== exp_r.ch ||
						run_last !== exp_r.last || is_float !== exp_r.flt ||
						sample_rate !== exp_r.rate || channel_count !== exp_r.chans ||
						sample_bits !== exp_r.bits || frame_count !== exp_r.frames ||
						status !== exp_r.st) begin
					error_count++;
					if (error_count <= 10) begin
						$display("mismatch: expected k=%0d v=%h ch=%0d l=%0d f=%0d r=%0d c=%0d b=%0d n=%0d s=%0d",
							exp_r.kind, exp_r.val, exp_r.ch, exp_r.last, exp_r.flt, exp_r.rate,
							exp_r.chans, exp_r.bits, exp_r.frames, exp_r.st);
						$display("          actual   k=%0d v=%h ch=%0d l=%0d f=%0d r=%0d c=%0d b=%0d n=%0d s=%0d",
							kind, sample_value, channel, run_last, is_float, sample_rate,
							channel_count, sample_bits, frame_count, status);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WatchdogLimit) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_bytes_before_first();
		test_pcm_formats();
		test_broken_files();
		test_backpressure();
		test_random_files();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) error_count++;
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
